// File: src/binary_to_ascii_hex_decimal_formatter_unit_defines.svh
// Assertion helpers used by the formatter controller.
// Both expect aclk and aresetn in scope.
`ifndef BINARY_TO_ASCII_HEX_DECIMAL_FORMATTER_UNIT_DEFINES_SVH
`define BINARY_TO_ASCII_HEX_DECIMAL_FORMATTER_UNIT_DEFINES_SVH

// same-cycle implication
`define BAHF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BAHF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bahf_pkg.sv
package bahf_pkg;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 6;

    localparam logic [FUNC_W-1:0] FUNC_HEX8  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_HEX16 = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEX32 = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SDEC8 = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DEC8  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DEC16 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_DEC32 = 3'd6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_HEXA  = 8'h57;  // 'a' minus ten
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;

    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;
    localparam logic [DIGIT_W-1:0] DD_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] DD_ADJUST = 4'd3;

    localparam logic [2:0] REG_ADDR_OUTPUT_ENABLE = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic dd_step;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic in_fmt_ok;
        logic in_hex;
        logic cnt_last;
        logic neg;
        logic digit_zero;
        logic idx_zero;
        logic out_free;
    } status_t;

endpackage

// File: src/bahf_dpath.sv
module bahf_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bahf_pkg::FUNC_W-1:0]       s_func,
    input  logic [bahf_pkg::VALUE_W-1:0]      s_value,
    input  bahf_pkg::cmd_t                    cmd,
    output bahf_pkg::status_t                 st,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bahf_pkg::CHAR_W-1:0]       m_char,
    output logic                              m_last
);

    logic [bahf_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [bahf_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [bahf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [bahf_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         neg_reg, neg_next;
    logic                         out_valid_reg, out_valid_next;
    logic [bahf_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                         out_last_reg, out_last_next;

    logic [bahf_pkg::VALUE_W-1:0] load_bin;
    logic [bahf_pkg::BCD_W-1:0]   load_bcd;
    logic [bahf_pkg::CNT_W-1:0]   load_cnt;
    logic [bahf_pkg::IDX_W-1:0]   load_idx;
    logic                         in_neg;
    logic                         in_hex;
    logic                         in_fmt_ok;
    logic [7:0]                   mag8;
    logic [bahf_pkg::BCD_W-1:0]   bcd_adj;
    logic [bahf_pkg::DIGIT_W-1:0] digit_cur;
    logic [bahf_pkg::CHAR_W-1:0]  digit_char;

    // item decode
    always_comb begin
        load_bin  = '0;
        load_bcd  = '0;
        load_cnt  = '0;
        load_idx  = '0;
        in_neg    = 1'b0;
        in_hex    = 1'b0;
        in_fmt_ok = 1'b1;
        mag8      = s_value[7:0];
        case (s_func)
            bahf_pkg::FUNC_HEX8: begin
                in_hex   = 1'b1;
                load_bcd = {32'd0, s_value[7:0]};
                load_idx = 4'd1;
            end
            bahf_pkg::FUNC_HEX16: begin
                in_hex   = 1'b1;
                load_bcd = {24'd0, s_value[15:0]};
                load_idx = 4'd3;
            end
            bahf_pkg::FUNC_HEX32: begin
                in_hex   = 1'b1;
                load_bcd = {8'd0, s_value};
                load_idx = 4'd7;
            end
            bahf_pkg::FUNC_SDEC8: begin
                in_neg   = s_value[7];
                // 0x80 negates to 0x80, read as 128 unsigned
                mag8     = s_value[7] ? 8'(~s_value[7:0] + 8'd1) : s_value[7:0];
                load_bin = {mag8, 24'd0};
                load_cnt = 6'd8;
                load_idx = 4'd2;
            end
            bahf_pkg::FUNC_DEC8: begin
                load_bin = {s_value[7:0], 24'd0};
                load_cnt = 6'd8;
                load_idx = 4'd2;
            end
            bahf_pkg::FUNC_DEC16: begin
                load_bin = {s_value[15:0], 16'd0};
                load_cnt = 6'd16;
                load_idx = 4'd4;
            end
            bahf_pkg::FUNC_DEC32: begin
                load_bin = s_value;
                load_cnt = 6'd32;
                load_idx = 4'd9;
            end
            default: begin
                in_fmt_ok = 1'b0;
            end
        endcase
    end

    // double-dabble correction, one independent adder per BCD digit
    always_comb begin
        for (int k = 0; k < bahf_pkg::DIGITS; k++) begin
            if (bcd_reg[k*bahf_pkg::DIGIT_W +: bahf_pkg::DIGIT_W] >= bahf_pkg::DD_LIMIT) begin
                bcd_adj[k*bahf_pkg::DIGIT_W +: bahf_pkg::DIGIT_W] =
                    bcd_reg[k*bahf_pkg::DIGIT_W +: bahf_pkg::DIGIT_W] + bahf_pkg::DD_ADJUST;
            end else begin
                bcd_adj[k*bahf_pkg::DIGIT_W +: bahf_pkg::DIGIT_W] =
                    bcd_reg[k*bahf_pkg::DIGIT_W +: bahf_pkg::DIGIT_W];
            end
        end
    end

    assign digit_cur = bcd_reg[{idx_reg, 2'b00} +: bahf_pkg::DIGIT_W];

    always_comb begin
        if (digit_cur < bahf_pkg::DIGIT_TEN) begin
            digit_char = bahf_pkg::ASCII_ZERO + {4'd0, digit_cur};
        end else begin
            digit_char = bahf_pkg::ASCII_HEXA + {4'd0, digit_cur};
        end
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        neg_next = neg_reg;
        if (cmd.load) begin
            bin_next = load_bin;
            bcd_next = load_bcd;
            cnt_next = load_cnt;
            idx_next = load_idx;
            neg_next = in_neg;
        end else if (cmd.dd_step) begin
            bcd_next = {bcd_adj[bahf_pkg::BCD_W-2:0], bin_reg[bahf_pkg::VALUE_W-1]};
            bin_next = {bin_reg[bahf_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
        end else if (cmd.skip || (cmd.emit_digit && idx_reg != '0)) begin
            idx_next = idx_reg - 4'd1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit_sign) begin
            out_valid_next = 1'b1;
            out_char_next  = bahf_pkg::ASCII_MINUS;
            out_last_next  = 1'b0;
        end else if (cmd.emit_digit) begin
            out_valid_next = 1'b1;
            out_char_next  = digit_char;
            out_last_next  = (idx_reg == '0);
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign st.in_fmt_ok  = in_fmt_ok;
    assign st.in_hex     = in_hex;
    assign st.cnt_last   = (cnt_reg == 6'd1);
    assign st.neg        = neg_reg;
    assign st.digit_zero = (digit_cur == '0);
    assign st.idx_zero   = (idx_reg == '0);
    assign st.out_free   = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_char  = out_char_reg;
    assign m_last  = out_last_reg;

endmodule

// File: src/bahf_ctrl.sv
`include "binary_to_ascii_hex_decimal_formatter_unit_defines.svh"

module bahf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               output_enable,
    input  bahf_pkg::status_t  st,
    output bahf_pkg::cmd_t     cmd
);

    bahf_pkg::state_t state_reg, state_next;
    logic             lead_zero;

    // leading zero of a decimal number, never the ones digit
    assign lead_zero = st.digit_zero && !st.idx_zero;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bahf_pkg::ST_IDLE: begin
                if (s_valid && output_enable && st.in_fmt_ok) begin
                    state_next = st.in_hex ? bahf_pkg::ST_EMIT : bahf_pkg::ST_CONVERT;
                end
            end
            bahf_pkg::ST_CONVERT: begin
                if (st.cnt_last) begin
                    state_next = st.neg ? bahf_pkg::ST_SIGN : bahf_pkg::ST_SCAN;
                end
            end
            bahf_pkg::ST_SIGN: begin
                if (st.out_free) begin
                    state_next = bahf_pkg::ST_SCAN;
                end
            end
            bahf_pkg::ST_SCAN: begin
                if (!lead_zero && st.out_free) begin
                    state_next = st.idx_zero ? bahf_pkg::ST_IDLE : bahf_pkg::ST_EMIT;
                end
            end
            bahf_pkg::ST_EMIT: begin
                if (st.out_free && st.idx_zero) begin
                    state_next = bahf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bahf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        case (state_reg)
            bahf_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid && output_enable && st.in_fmt_ok;
            end
            bahf_pkg::ST_CONVERT: begin
                cmd.dd_step = 1'b1;
            end
            bahf_pkg::ST_SIGN: begin
                cmd.emit_sign = st.out_free;
            end
            bahf_pkg::ST_SCAN: begin
                cmd.skip       = lead_zero;
                cmd.emit_digit = !lead_zero && st.out_free;
            end
            bahf_pkg::ST_EMIT: begin
                cmd.emit_digit = st.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bahf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `BAHF_ASSERT_IMPL(a_emit_has_room, cmd.emit_sign || cmd.emit_digit, st.out_free, "word loaded over an untaken word")
    `BAHF_ASSERT_IMPL(a_sign_only_neg, cmd.emit_sign, st.neg, "minus sign for a non-negative number")
    `BAHF_ASSERT_NEXT(a_last_to_idle, cmd.emit_digit && st.idx_zero, state_reg == bahf_pkg::ST_IDLE, "no return to idle after last character")
    `BAHF_ASSERT_IMPL(a_one_command, 1'b1, $onehot0(cmd), "more than one datapath command")

endmodule

// File: src/binary_to_ascii_hex_decimal_formatter_unit.sv
// Order: for hex, the emit state follows the accepting edge and registers all N digits
// (N = 2, 4, 8); for decimal, W double-dabble shifts (W = 8, 16 or 32) come first, then the
// scan state skips each suppressed leading zero; a minus sign, when present, comes first.
// A new number is taken only in the idle state, once the last character of the one before
// is registered; each character waits while the output word is not yet taken.
// Reset (aresetn low, synchronous): controller idle, output word dropped, output_enable = 1.
module binary_to_ascii_hex_decimal_formatter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bahf_pkg::cmd_t    cmd;
    bahf_pkg::status_t st;
    logic              oe_reg, oe_next;
    logic              oe_hit;

    assign oe_hit = (paddr == bahf_pkg::REG_ADDR_OUTPUT_ENABLE);
    assign pready = 1'b1;
    assign prdata = oe_hit ? {31'd0, oe_reg} : 32'd0;

    always_comb begin
        oe_next = oe_reg;
        if (psel && penable && pwrite && pready && oe_hit) begin
            oe_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oe_reg <= 1'b1;
        end else begin
            oe_reg <= oe_next;
        end
    end

    bahf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .output_enable (oe_reg),
        .st            (st),
        .cmd           (cmd)
    );

    bahf_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_func  (s_axis_tuser),
        .s_value (s_axis_tdata),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_char  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule

// File: tb/binary_to_ascii_hex_decimal_formatter_unit_test.sv
`timescale 1ns / 1ps

module binary_to_ascii_hex_decimal_formatter_unit_test;

    localparam logic [2:0] FUNC_UNUSED     = 3'd7;
    localparam logic [2:0] REG_ADDR_UNUSED = 3'd4;   // address 4, not implemented
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_A     = "a";
    localparam logic [7:0] CH_MINUS = "-";
    localparam int SETTLE_CYCLES = 64;    // worst decimal conversion plus margin
    localparam int RX_HOLD_LEN   = 300;
    localparam int LIMIT_CYCLES  = 200000;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] value;
    } number_t;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [2:0]  s_axis_tuser = '0;   // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] char_code
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    number_t     pending_numbers[$];
    char_t       expected_chars[$];
    logic [7:0]  number_text[$];
    number_t     next_number;
    char_t       want;

    logic        out_enabled = 1'b1;
    logic        word_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          rx_hold_requests = 0;
    int          rx_hold_served = 0;
    int          rx_hold_left = 0;
    int          numbers_queued = 0;
    int          numbers_accepted = 0;
    int          chars_checked = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int unsigned pow10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                               10000000, 100000000, 1000000000};

    binary_to_ascii_hex_decimal_formatter_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 aclk = ~aclk;

    // ---------------- formatter prediction ----------------
    function automatic void put_hex_digits(input logic [31:0] v, input int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = v[i*4 +: 4];
            if (nib < 4'd10)
                number_text.push_back(CH_ZERO + {4'b0, nib});
            else
                number_text.push_back(CH_A + {4'b0, nib} - 8'd10);
        end
    endfunction

    // leading zeros dropped, but the ones digit always prints
    function automatic void put_dec_digits(input logic [31:0] v, input logic [31:0] div);
        logic [31:0] rest;
        logic [31:0] digit;
        bit          started;
        rest = v;
        started = 1'b0;
        while (div != 0) begin
            digit = rest / div;
            if (digit != 0 || started || div == 1) begin
                number_text.push_back(CH_ZERO + digit[7:0]);
                started = 1'b1;
            end
            rest = rest - digit * div;
            div = div / 10;
        end
    endfunction

    function automatic void predict_chars(input logic [2:0] func, input logic [31:0] value);
        logic [8:0] mag;
        number_text.delete();
        if (out_enabled) begin
            case (func)
                bahf_pkg::FUNC_HEX8:  put_hex_digits({24'b0, value[7:0]}, 2);
                bahf_pkg::FUNC_HEX16: put_hex_digits({16'b0, value[15:0]}, 4);
                bahf_pkg::FUNC_HEX32: put_hex_digits(value, 8);
                bahf_pkg::FUNC_SDEC8: begin
                    mag = {1'b0, value[7:0]};
                    if (value[7]) begin
                        number_text.push_back(CH_MINUS);
                        mag = 9'h100 - mag;   // 0x80 gives 128, no overflow
                    end
                    put_dec_digits({23'b0, mag}, 32'd100);
                end
                bahf_pkg::FUNC_DEC8:  put_dec_digits({24'b0, value[7:0]}, 32'd100);
                bahf_pkg::FUNC_DEC16: put_dec_digits({16'b0, value[15:0]}, 32'd10000);
                bahf_pkg::FUNC_DEC32: put_dec_digits(value, 32'd1000000000);
                default: ;
            endcase
        end
        for (int i = 0; i < number_text.size(); i++)
            expected_chars.push_back('{code: number_text[i],
                                       last: (i == number_text.size() - 1)});
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void queue_number(input logic [2:0] func, input logic [31:0] value);
        pending_numbers.push_back('{func: func, value: value});
        numbers_queued++;
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(1, 31);
            2: v = pow10[$urandom_range(0, 9)] - $urandom_range(0, 1);
            3: begin
                v = $urandom;
                v[7:0] = 8'($urandom_range(120, 136));   // around the int8 sign boundary
            end
            default: v = $urandom_range(0, 300);
        endcase
        return v;
    endfunction

    function automatic logic [2:0] random_func();
        if ($urandom_range(0, 19) == 0)
            return FUNC_UNUSED;
        return 3'($urandom_range(bahf_pkg::FUNC_HEX8, bahf_pkg::FUNC_DEC32));
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_number(random_func(), random_value());
    endtask

    task automatic wait_drained(input int settle);
        while (numbers_accepted != numbers_queued || expected_chars.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------- number driver ----------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_number = pending_numbers.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_number.value;
                s_axis_tuser  <= next_number.func;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- character receiver ----------------
    always @(negedge aclk) begin
        if (rx_hold_served != rx_hold_requests) begin
            rx_hold_served <= rx_hold_served + 1;
            rx_hold_left   <= RX_HOLD_LEN;
            m_axis_tready  <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        word_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn) begin
            if (psel && penable && pwrite && pready
                && paddr == bahf_pkg::REG_ADDR_OUTPUT_ENABLE)
                out_enabled = pwdata[0];
            if (s_axis_tvalid && s_axis_tready) begin
                predict_chars(s_axis_tuser, s_axis_tdata);
                numbers_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.code) begin
                        error_count++;
                        $display("%0t: char_code mismatch: expected %h, actual %h",
                                 $time, want.code, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last) begin
                        error_count++;
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d characters still expected",
                     $time, expected_chars.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, every format, sign edge, unused code
        queue_number(bahf_pkg::FUNC_HEX8,   32'hffff_ff00);
        queue_number(bahf_pkg::FUNC_HEX8,   32'h0000_00ff);
        queue_number(bahf_pkg::FUNC_HEX16,  32'hffff_0000);
        queue_number(bahf_pkg::FUNC_HEX16,  32'h0000_ffff);
        queue_number(bahf_pkg::FUNC_HEX16,  32'h0000_a5c3);
        queue_number(bahf_pkg::FUNC_HEX32,  32'h0000_0000);
        queue_number(bahf_pkg::FUNC_HEX32,  32'hffff_ffff);
        queue_number(bahf_pkg::FUNC_HEX32,  32'h0123_4567);
        queue_number(bahf_pkg::FUNC_HEX32,  32'h89ab_cdef);
        queue_number(bahf_pkg::FUNC_SDEC8,  32'hffff_ff80);
        queue_number(bahf_pkg::FUNC_SDEC8,  32'h0000_007f);
        queue_number(bahf_pkg::FUNC_SDEC8,  32'h0000_0000);
        queue_number(bahf_pkg::FUNC_SDEC8,  32'h0000_00ff);
        queue_number(bahf_pkg::FUNC_SDEC8,  32'h0000_0185);
        queue_number(bahf_pkg::FUNC_SDEC8,  32'h0000_000a);
        queue_number(bahf_pkg::FUNC_DEC8,   32'hffff_ff00);
        queue_number(bahf_pkg::FUNC_DEC8,   32'h0000_00ff);
        queue_number(bahf_pkg::FUNC_DEC16,  32'h0000_0000);
        queue_number(bahf_pkg::FUNC_DEC16,  32'h0000_ffff);
        queue_number(bahf_pkg::FUNC_DEC16,  32'h0000_2710);
        queue_number(bahf_pkg::FUNC_DEC32,  32'h0000_0000);
        queue_number(bahf_pkg::FUNC_DEC32,  32'hffff_ffff);
        queue_number(bahf_pkg::FUNC_DEC32,  32'h3b9a_ca00);
        queue_number(FUNC_UNUSED,           32'hffff_ffff);
        wait_drained(SETTLE_CYCLES);

        // output off; only bit 0 of the register counts
        apb_write(bahf_pkg::REG_ADDR_OUTPUT_ENABLE, 32'hffff_fffe);
        queue_random(8);
        wait_drained(SETTLE_CYCLES);
        apb_write(bahf_pkg::REG_ADDR_OUTPUT_ENABLE, 32'h0000_0001);
        apb_write(REG_ADDR_UNUSED, 32'h0000_0000);   // must not disable output

        send_idle_pct = 17;
        recv_idle_pct = 49;
        queue_random(35);
        wait_drained(0);   // sender holds until every character is out
        queue_random(30);
        wait_drained(SETTLE_CYCLES);

        apb_write(bahf_pkg::REG_ADDR_OUTPUT_ENABLE, 32'h0000_0000);
        queue_random(6);
        wait_drained(SETTLE_CYCLES);
        apb_write(bahf_pkg::REG_ADDR_OUTPUT_ENABLE, 32'hffff_ffff);

        send_idle_pct = 49;
        recv_idle_pct = 17;
        queue_random(65);
        wait_drained(SETTLE_CYCLES);

        // no idling; a long receiver stall backs up into the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_requests = rx_hold_requests + 1;
        queue_random(70);
        wait_drained(SETTLE_CYCLES);

        $display("Checked %0d characters from %0d numbers: all formats, unused code,",
                 chars_checked, numbers_accepted);
        $display("output on/off, ignored register index and a long output stall.");
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
